[sv/pee_pkg.sv]
// Shared types, constants and helpers of the percent-escape encoder.
package pee_pkg;

  localparam int unsigned QueueDepthDef = 4;
  localparam logic [15:0] BufLenReset   = 16'd256;
  localparam int unsigned AddrW         = 3;
  localparam logic [AddrW-1:0] RegBufLenAddr = 3'd0;

  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharTerm    = 8'h00;

  typedef enum logic [1:0] {
    CMD_PASS = 2'd0,
    CMD_ESC  = 2'd1,
    CMD_TERM = 2'd2
  } pee_kind_e;

  typedef struct packed {
    pee_kind_e  kind;
    logic [7:0] ch;
    logic       status;
  } pee_cmd_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h61 + {4'd0, v} - 8'd10);
  endfunction

endpackage

[sv/percent_escape_encoder_core.sv]
// Top level of the percent-escape encoder: config register, front, queue, back.
//
// Source bytes arrive on the s_axis channel (tdata = in_byte); a zero byte
// ends a string. Characters leave on the m_axis channel: tdata = out_char,
// tlast = last character caused by one source byte, tuser[0] = string end
// (terminator), tuser[1] = status on the terminator.
// Letters and digits take one output transfer, other bytes three (%hh),
// the terminator one. Bytes dropped for budget reasons produce nothing.
// Commands pass through the queue and then the back end's command register.
// Throughput: one byte per cycle on input while the command queue has room;
// the output side sustains one character per cycle while the receiver is
// ready; the character generator steps an escaped byte through %, hi, lo.
// A stalled receiver fills the queue; tready then drops until an entry frees.
// Reset clears the budget state and the queue, and sets buffer_length to 256.
// buffer_length is written over APB at address 0 and takes effect at the
// first byte of the next string.
module percent_escape_encoder_core import pee_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] in_byte
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] out_char
  output logic             m_axis_tlast,
  output logic [1:0]       m_axis_tuser    // [0] string_end, [1] status
);

  logic [15:0] buf_len_q;
  logic        reg_sel;
  logic        q_full, q_push, q_pop, q_valid;
  pee_cmd_t    q_wr_cmd, q_rd_cmd;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[AddrW-1:2] == RegBufLenAddr[AddrW-1:2]);
  assign prdata  = reg_sel ? {16'd0, buf_len_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_len_q <= BufLenReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      buf_len_q <= pwdata[15:0];
    end
  end

  pee_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .buf_len_i  (buf_len_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_wr_cmd)
  );

  pee_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .wr_cmd_i (q_wr_cmd),
    .full_o   (q_full),
    .pop_i    (q_pop),
    .valid_o  (q_valid),
    .rd_cmd_o (q_rd_cmd)
  );

  pee_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_cmd_i      (q_rd_cmd),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_char_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast),
    .out_end_o    (m_axis_tuser[0]),
    .out_status_o (m_axis_tuser[1])
  );

endmodule

[sv/pee_front.sv]
// Front end: accepts source bytes, tracks the budget and classifies each byte.
module pee_front import pee_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] buf_len_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output pee_cmd_t    q_cmd_o
);

  logic [15:0] remaining_q, remaining_d;
  logic        in_string_q, in_string_d;
  logic        stopped_q, stopped_d;
  logic [15:0] base;
  logic        accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    base = in_string_q ? remaining_q :
           ((buf_len_i == 16'd0) ? 16'd0 : buf_len_i - 16'd1);
    remaining_d     = remaining_q;
    in_string_d     = in_string_q;
    stopped_d       = stopped_q;
    q_push_o        = 1'b0;
    q_cmd_o.kind    = CMD_PASS;
    q_cmd_o.ch      = in_byte_i;
    q_cmd_o.status  = 1'b0;
    if (accept) begin
      if (in_byte_i == 8'd0) begin
        q_push_o       = 1'b1;
        q_cmd_o.kind   = CMD_TERM;
        q_cmd_o.status = stopped_q;
        remaining_d    = 16'd0;
        in_string_d    = 1'b0;
        stopped_d      = 1'b0;
      end else begin
        in_string_d = 1'b1;
        remaining_d = base;
        if (!stopped_q && base != 16'd0) begin
          if (is_alnum(in_byte_i)) begin
            q_push_o    = 1'b1;
            remaining_d = base - 16'd1;
          end else if (base < 16'd3) begin
            stopped_d = 1'b1;
          end else begin
            q_push_o     = 1'b1;
            q_cmd_o.kind = CMD_ESC;
            remaining_d  = base - 16'd3;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= 16'd0;
      in_string_q <= 1'b0;
      stopped_q   <= 1'b0;
    end else begin
      remaining_q <= remaining_d;
      in_string_q <= in_string_d;
      stopped_q   <= stopped_d;
    end
  end

  a_stop_in_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> in_string_q)
    else $error("stopped set outside a string");

endmodule

[sv/pee_queue.sv]
// Command queue between the front end and the character generator.
module pee_queue import pee_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  pee_cmd_t wr_cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output pee_cmd_t rd_cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pee_cmd_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                do_push, do_pop;

  assign full_o   = (count_q == CntW'(Depth));
  assign valid_o  = (count_q != '0);
  assign rd_cmd_o = mem_q[rd_ptr_q];
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wr_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

endmodule

[sv/pee_back.sv]
// Back end: expands queued commands into output characters.
module pee_back import pee_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  pee_cmd_t q_cmd_i,
  output logic     q_pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output logic [7:0] out_char_o,
  output logic     out_last_o,
  output logic     out_end_o,
  output logic     out_status_o
);

  logic       busy_q, busy_d;
  pee_cmd_t   cmd_q, cmd_d;
  logic [1:0] phase_q, phase_d;
  logic       fire, done;

  always_comb begin
    out_char_o = cmd_q.ch;
    out_last_o = 1'b1;
    unique case (cmd_q.kind)
      CMD_PASS: out_char_o = cmd_q.ch;
      CMD_TERM: out_char_o = CharTerm;
      CMD_ESC: begin
        out_last_o = (phase_q == 2'd2);
        case (phase_q)
          2'd0:    out_char_o = CharPercent;
          2'd1:    out_char_o = hex_digit(cmd_q.ch[7:4]);
          default: out_char_o = hex_digit(cmd_q.ch[3:0]);
        endcase
      end
      default: out_char_o = cmd_q.ch;
    endcase
  end

  assign out_end_o    = (cmd_q.kind == CMD_TERM);
  assign out_status_o = out_end_o && cmd_q.status;
  assign out_valid_o  = busy_q;
  assign fire         = busy_q && out_ready_i;
  assign done         = fire && out_last_o;
  assign q_pop_o      = q_valid_i && (!busy_q || done);

  always_comb begin
    busy_d  = busy_q;
    cmd_d   = cmd_q;
    phase_d = phase_q;
    if (q_pop_o) begin
      busy_d  = 1'b1;
      cmd_d   = q_cmd_i;
      phase_d = 2'd0;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (fire) begin
      phase_d = phase_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 2'd0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
    end
  end

  a_phase_only_esc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cmd_q.kind != CMD_ESC |-> phase_q == 2'd0)
    else $error("nonzero phase on single-character command");

  a_term_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_end_o |-> out_last_o)
    else $error("terminator not marked last");

  a_escape_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !out_last_o |=> busy_q && $stable(cmd_q) && phase_q == $past(phase_q) + 2'd1)
    else $error("escape sequence interrupted");

endmodule
